### design/skf_pkg.sv
// Shared types, widths and constants of the scalar Kalman filter unit.
`default_nettype none

package skf_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int GAIN_W        = FRACTION_BITS + 1;
    localparam int MAG_W         = VALUE_WIDTH + 1;
    localparam int ALU_W         = VALUE_WIDTH + 2;
    localparam int PROD_W        = MAG_W + GAIN_W;
    localparam int CNT_W         = $clog2(FRACTION_BITS);
    localparam int CFG_IDX_W     = 2;

    localparam logic [VALUE_WIDTH-1:0] VAR_RESET =
        VALUE_WIDTH'(((2 << FRACTION_BITS) + 50) / 100);
    localparam logic [VALUE_WIDTH-1:0] Q_RESET =
        VALUE_WIDTH'(((1 << FRACTION_BITS) + 50) / 100);
    localparam logic [VALUE_WIDTH-1:0] R_RESET =
        VALUE_WIDTH'(5 << FRACTION_BITS);
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRACTION_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = CFG_IDX_W'(1);

    typedef enum logic [0:0] {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_PRED,
        PH_DEN,
        PH_DIV0,
        PH_DIV,
        PH_ONEM,
        PH_ERR,
        PH_ABS,
        PH_MULE,
        PH_UPD,
        PH_MULP,
        PH_VAR,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   ready;
        logic   load_out;
    } ctrl_t;

    typedef struct packed {
        logic den_zero;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

### design/skf_alu.sv
// Shared add/subtract unit; the top carry bit doubles as borrow flag.
`default_nettype none

module skf_alu
    import skf_pkg::*;
(
    input  alu_op_t          op,
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    output logic [ALU_W:0]   res
);

    always_comb begin
        case (op)
            ALU_ADD: res = {1'b0, a} + {1'b0, b};
            ALU_SUB: res = {1'b0, a} - {1'b0, b};
            default: res = {1'b0, a};
        endcase
    end

endmodule

`default_nettype wire

### design/skf_seq.sv
// Sequencer: steps one sample through the shared adder and multiplier.
`default_nettype none

module skf_seq
    import skf_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  stat_t stat,
    output ctrl_t ctrl
);

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        ctrl.phase     = phase_reg;
        ctrl.ready     = 1'b0;
        ctrl.load_out  = 1'b0;
        case (phase_reg)
            PH_IDLE: begin
                ctrl.ready = 1'b1;
                if (s_valid) begin
                    phase_next = PH_PRED;
                end
            end
            PH_PRED: phase_next = PH_DEN;
            PH_DEN: begin
                phase_next = stat.den_zero ? PH_ONEM : PH_DIV0;
            end
            PH_DIV0: begin
                cnt_next   = '0;
                phase_next = PH_DIV;
            end
            PH_DIV: begin
                if (cnt_reg == CNT_W'(FRACTION_BITS - 1)) begin
                    phase_next = PH_ONEM;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            PH_ONEM: phase_next = PH_ERR;
            PH_ERR:  phase_next = PH_ABS;
            PH_ABS:  phase_next = PH_MULE;
            PH_MULE: phase_next = PH_UPD;
            PH_UPD:  phase_next = PH_MULP;
            PH_MULP: phase_next = PH_VAR;
            PH_VAR:  phase_next = PH_DONE;
            PH_DONE: begin
                if (stat.out_free) begin
                    ctrl.load_out = 1'b1;
                    phase_next    = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### design/scalar_kalman_filter_unit.sv
// Top level: scalar Kalman filter datapath, config registers and result register.
`default_nettype none

// One sample is taken while idle; the next sample is taken only after the
// result of the last one has been loaded into the output register. The gain
// divider is restoring, one quotient bit per cycle through the single shared
// adder; when the predicted variance plus measurement noise is zero the
// division is skipped and the gain is set to one. A finished result waits in
// the output register while the next sample is being processed; the block
// stalls before overwriting it. Config writes take effect at once, so make
// them only while the block is idle with no sample in flight.
module scalar_kalman_filter_unit
    import skf_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [VALUE_WIDTH-1:0]        cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_WIDTH-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [VALUE_WIDTH-1:0] m_estimate,
    output logic [GAIN_W-1:0]             m_gain
);

    ctrl_t ctrl;
    stat_t stat;

    logic [VALUE_WIDTH-1:0] q_reg, q_next;
    logic [VALUE_WIDTH-1:0] r_reg, r_next;
    logic [VALUE_WIDTH-1:0] ev_reg, ev_next;
    logic [VALUE_WIDTH-1:0] fv_reg, fv_next;
    logic [VALUE_WIDTH-1:0] sample_reg, sample_next;
    logic [VALUE_WIDTH-1:0] pred_reg, pred_next;
    logic [MAG_W-1:0]       den_reg, den_next;
    logic [ALU_W-1:0]       rem_reg, rem_next;
    logic [GAIN_W-1:0]      quo_reg, quo_next;
    logic [GAIN_W-1:0]      kc_reg, kc_next;
    logic [MAG_W-1:0]       err_reg, err_next;
    logic [MAG_W-1:0]       mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic                   m_valid_reg, m_valid_next;
    logic [VALUE_WIDTH-1:0] est_reg;
    logic [GAIN_W-1:0]      gain_reg;

    alu_op_t          alu_op;
    logic [ALU_W-1:0] alu_a, alu_b;
    logic [ALU_W:0]   alu_res;
    logic [ALU_W-1:0] rem_shift;
    logic             div_ge;
    logic [MAG_W-1:0] mul_a;
    logic [GAIN_W-1:0] mul_b;

    skf_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    skf_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    assign s_ready    = ctrl.ready;
    assign m_valid    = m_valid_reg;
    assign m_estimate = est_reg;
    assign m_gain     = gain_reg;

    assign rem_shift     = {rem_reg[ALU_W-2:0], 1'b0};
    assign div_ge        = !alu_res[ALU_W];
    assign stat.den_zero = (alu_res[VALUE_WIDTH:0] == '0);
    assign stat.out_free = !m_valid_reg || m_ready;

    // operand select for the shared adder and multiplier
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        mul_a  = mag_reg;
        mul_b  = quo_reg;
        case (ctrl.phase)
            PH_PRED: begin
                alu_a = ALU_W'(ev_reg);
                alu_b = ALU_W'(q_reg);
            end
            PH_DEN: begin
                alu_a = ALU_W'(pred_reg);
                alu_b = ALU_W'(r_reg);
            end
            PH_DIV0: begin
                alu_op = ALU_SUB;
                alu_a  = rem_reg;
                alu_b  = ALU_W'(den_reg);
            end
            PH_DIV: begin
                alu_op = ALU_SUB;
                alu_a  = rem_shift;
                alu_b  = ALU_W'(den_reg);
            end
            PH_ONEM: begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(GAIN_ONE);
                alu_b  = ALU_W'(quo_reg);
            end
            PH_ERR: begin
                alu_op = ALU_SUB;
                alu_a  = {{2{sample_reg[VALUE_WIDTH-1]}}, sample_reg};
                alu_b  = {{2{fv_reg[VALUE_WIDTH-1]}}, fv_reg};
            end
            PH_ABS: begin
                alu_op = ALU_SUB;
                alu_b  = {err_reg[MAG_W-1], err_reg};
            end
            PH_UPD: begin
                alu_op = neg_reg ? ALU_SUB : ALU_ADD;
                alu_a  = {{2{fv_reg[VALUE_WIDTH-1]}}, fv_reg};
                alu_b  = prod_reg[PROD_W-1:FRACTION_BITS];
            end
            PH_MULP: begin
                mul_a = {1'b0, pred_reg};
                mul_b = kc_reg;
            end
            default: begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    always_comb begin
        q_next       = q_reg;
        r_next       = r_reg;
        ev_next      = ev_reg;
        fv_next      = fv_reg;
        sample_next  = sample_reg;
        pred_next    = pred_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        kc_next      = kc_reg;
        err_next     = err_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        prod_next    = prod_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_PROCESS_NOISE:     q_next = cfg_wr_data;
                REG_MEASUREMENT_NOISE: r_next = cfg_wr_data;
                default: ;
            endcase
        end

        case (ctrl.phase)
            PH_IDLE: begin
                if (s_valid) begin
                    sample_next = s_sample;
                end
            end
            PH_PRED: begin
                pred_next = alu_res[VALUE_WIDTH] ? '1 : alu_res[VALUE_WIDTH-1:0];
            end
            PH_DEN: begin
                den_next = alu_res[VALUE_WIDTH:0];
                rem_next = ALU_W'(pred_reg);
                quo_next = stat.den_zero ? GAIN_ONE : '0;
            end
            PH_DIV0: begin
                rem_next = div_ge ? alu_res[ALU_W-1:0] : rem_reg;
                quo_next = {quo_reg[GAIN_W-2:0], div_ge};
            end
            PH_DIV: begin
                rem_next = div_ge ? alu_res[ALU_W-1:0] : rem_shift;
                quo_next = {quo_reg[GAIN_W-2:0], div_ge};
            end
            PH_ONEM: kc_next  = alu_res[GAIN_W-1:0];
            PH_ERR:  err_next = alu_res[MAG_W-1:0];
            PH_ABS: begin
                neg_next = err_reg[MAG_W-1];
                mag_next = err_reg[MAG_W-1] ? alu_res[MAG_W-1:0] : err_reg;
            end
            PH_MULE, PH_MULP: begin
                prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
            end
            PH_UPD:  fv_next = alu_res[VALUE_WIDTH-1:0];
            PH_VAR:  ev_next = prod_reg[FRACTION_BITS +: VALUE_WIDTH];
            default: ;
        endcase

        if (ctrl.load_out) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg       <= Q_RESET;
            r_reg       <= R_RESET;
            ev_reg      <= VAR_RESET;
            fv_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            q_reg       <= q_next;
            r_reg       <= r_next;
            ev_reg      <= ev_next;
            fv_reg      <= fv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        pred_reg   <= pred_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        kc_reg     <= kc_next;
        err_reg    <= err_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
        if (ctrl.load_out) begin
            est_reg  <= fv_reg;
            gain_reg <= quo_reg;
        end
    end

    // gain never exceeds 1.0
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (gain_reg <= GAIN_ONE))
        else $error("gain above one");

    // partial remainder stays below the divisor during iteration
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.phase == PH_DIV) |-> (rem_reg < ALU_W'(den_reg)))
        else $error("remainder not below divisor");

    // scaled correction never exceeds the error magnitude
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.phase == PH_UPD) |-> (prod_reg[PROD_W-1:FRACTION_BITS] <= ALU_W'(mag_reg)))
        else $error("correction larger than error");

    // a pending result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_out |-> (!m_valid_reg || m_ready))
        else $error("result overwritten");

    // no new sample while a sample is in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("transfer during processing");

endmodule

`default_nettype wire
